// ===== hdl/pkwrt_pkg.sv =====
// pkwrt_pkg: shared types and constants for the per-key window rate tracker
// no dependencies
`default_nettype none
package pkwrt_pkg;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TimeW  = 63;
  localparam int unsigned CountW = 31;
  localparam int unsigned LimW   = 7;

  typedef enum logic [1:0] {
    CMD_NOTE  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [0:0] REG_WINDOW_LEN  = 1'b1;

  localparam logic [LimW-1:0]  MaxEntriesReset = 7'd64;
  localparam logic [TimeW-1:0] WindowLenReset  = 63'd1000000000;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    cmd_e             cmd;
    logic [KeyW-1:0]  key_id;
    logic [TimeW-1:0] event_time;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] peak_rate;
    logic              key_present;
    logic              dropped;
  } rsp_t;
endpackage
`default_nettype wire

// ===== hdl/pkwrt_front.sv =====
// pkwrt_front: input stage and two-entry request queue
// depends on pkwrt_pkg
`default_nettype none
module pkwrt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  pkwrt_pkg::req_t  req_i,
  output logic             req_valid_o,
  input  logic             req_take_i,
  output pkwrt_pkg::req_t  req_o
);
  pkwrt_pkg::req_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            wr, rd;

  assign full_o      = cnt_q[1];
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o       = mem_q[rp_q];
  assign wr          = push_i && !full_o;
  assign rd          = req_take_i && req_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= req_i;
  end
endmodule
`default_nettype wire

// ===== hdl/pkwrt_back.sv =====
// pkwrt_back: table search and read-modify-write engine with result register
// depends on pkwrt_pkg
`default_nettype none
module pkwrt_back #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_take_o,
  input  pkwrt_pkg::req_t                req_i,
  input  logic [pkwrt_pkg::LimW-1:0]     max_entries_i,
  input  logic [pkwrt_pkg::TimeW-1:0]    window_len_i,
  output logic                           busy_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output pkwrt_pkg::rsp_t                rsp_o
);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_CALC  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [pkwrt_pkg::KeyW-1:0]   key;
    logic [pkwrt_pkg::TimeW-1:0]  start;
    logic [pkwrt_pkg::CountW-1:0] count;
    logic [pkwrt_pkg::CountW-1:0] peak;
  } entry_t;

  entry_t                mem_q [TABLE_DEPTH];
  entry_t                rd_q;
  entry_t                hit_ent_q;
  logic [TABLE_DEPTH-1:0] used_q;
  logic [CntW-1:0]       total_q;
  state_e                state_q;
  pkwrt_pkg::req_t       cur_q;
  logic [IdxW-1:0]       idx_q, cmp_idx_q, hit_q, free_q;
  logic                  hit_v_q, free_v_q, cmp_v_q;
  logic                  out_v_q;
  pkwrt_pkg::rsp_t       out_q, res_q;
  logic                  idx_last;
  logic                  cmp_en;
  logic                  key_match;
  logic                  ins_ok;
  logic                  out_load;
  logic [CntW-1:0]       limit;
  logic [pkwrt_pkg::TimeW-1:0] diff;
  logic                  expired;
  logic [pkwrt_pkg::CountW-1:0] cnt_inc;
  logic                  we;
  logic [IdxW-1:0]       wa;
  entry_t                wd;

  assign idx_last  = {{(32-IdxW){1'b0}}, idx_q} == TABLE_DEPTH - 1;
  // entry read at cmp_idx_q is registered in rd_q and compared in the cycle after its address
  assign cmp_en    = (state_q == ST_SCAN || state_q == ST_WAIT) && cmp_v_q;
  assign key_match = cmp_en && used_q[cmp_idx_q] && rd_q.key == cur_q.key_id;
  assign limit = ({{(32-pkwrt_pkg::LimW){1'b0}}, max_entries_i} < TABLE_DEPTH) ?
                 CntW'(max_entries_i) : CntW'(TABLE_DEPTH);
  assign diff    = cur_q.event_time - hit_ent_q.start;
  assign expired = cur_q.event_time >= hit_ent_q.start && diff >= window_len_i;
  assign cnt_inc = (hit_ent_q.count == pkwrt_pkg::CountMax) ? hit_ent_q.count :
                   hit_ent_q.count + pkwrt_pkg::CountW'(1);
  assign ins_ok   = total_q < limit && free_v_q;
  assign out_load = state_q == ST_OUT && (!out_v_q || pop_i);

  assign req_take_o = state_q == ST_IDLE;
  assign busy_o     = state_q != ST_IDLE || out_v_q;
  assign empty_o    = !out_v_q;
  assign rsp_o      = out_q;

  always_comb begin
    we = 1'b0;
    wa = hit_q;
    wd = hit_ent_q;
    if (state_q == ST_CALC && cur_q.cmd == pkwrt_pkg::CMD_NOTE) begin
      if (hit_v_q) begin
        we = 1'b1;
        if (expired) begin
          wd.start = cur_q.event_time;
          wd.count = pkwrt_pkg::CountW'(1);
        end else begin
          wd.count = cnt_inc;
          if (hit_ent_q.peak < cnt_inc) wd.peak = cnt_inc;
        end
      end else if (ins_ok) begin
        we = 1'b1;
        wa = free_q;
        wd.key   = cur_q.key_id;
        wd.start = cur_q.event_time;
        wd.count = pkwrt_pkg::CountW'(1);
        wd.peak  = pkwrt_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      total_q   <= '0;
      cur_q     <= '0;
      out_v_q   <= 1'b0;
      out_q     <= '0;
      res_q     <= '0;
      idx_q     <= '0;
      cmp_idx_q <= '0;
      cmp_v_q   <= 1'b0;
      hit_q     <= '0;
      free_q    <= '0;
      hit_v_q   <= 1'b0;
      free_v_q  <= 1'b0;
      hit_ent_q <= '0;
    end else begin
      if (out_load) begin
        out_q   <= res_q;
        out_v_q <= 1'b1;
      end else if (pop_i && out_v_q) begin
        out_v_q <= 1'b0;
      end
      if (cmp_en) begin
        if (!hit_v_q && key_match) begin
          hit_v_q   <= 1'b1;
          hit_q     <= cmp_idx_q;
          hit_ent_q <= rd_q;
        end
        if (!free_v_q && !used_q[cmp_idx_q]) begin
          free_v_q <= 1'b1;
          free_q   <= cmp_idx_q;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            cur_q    <= req_i;
            idx_q    <= '0;
            cmp_v_q  <= 1'b0;
            hit_v_q  <= 1'b0;
            free_v_q <= 1'b0;
            if (req_i.cmd == pkwrt_pkg::CMD_CLEAR) begin
              used_q  <= '0;
              total_q <= '0;
              res_q   <= '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_idx_q <= idx_q;
          cmp_v_q   <= 1'b1;
          if (idx_last) begin
            state_q <= ST_WAIT;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_WAIT: state_q <= ST_CALC;
        ST_CALC: begin
          if (hit_v_q) begin
            res_q.key_present <= 1'b1;
            res_q.dropped     <= 1'b0;
            res_q.peak_rate   <= (cur_q.cmd == pkwrt_pkg::CMD_NOTE) ? wd.peak : hit_ent_q.peak;
          end else if (cur_q.cmd == pkwrt_pkg::CMD_NOTE && ins_ok) begin
            used_q[free_q]    <= 1'b1;
            total_q           <= total_q + CntW'(1);
            res_q.key_present <= 1'b1;
            res_q.dropped     <= 1'b0;
            res_q.peak_rate   <= pkwrt_pkg::CountW'(1);
          end else begin
            res_q.key_present <= 1'b0;
            res_q.peak_rate   <= '0;
            res_q.dropped     <= cur_q.cmd == pkwrt_pkg::CMD_NOTE;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/pkwrt_cfg.sv =====
// pkwrt_cfg: apb register file for limit and window length
// depends on pkwrt_pkg
`default_nettype none
module pkwrt_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output logic [pkwrt_pkg::LimW-1:0]  max_entries_o,
  output logic [pkwrt_pkg::TimeW-1:0] window_len_o
);
  logic [pkwrt_pkg::LimW-1:0]  max_q;
  logic [pkwrt_pkg::TimeW-1:0] win_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && paddr[2:0] == 3'd0;
  assign max_entries_o = max_q;
  assign window_len_o  = win_q;

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (paddr[3])
        pkwrt_pkg::REG_MAX_ENTRIES: prdata = {57'd0, max_q};
        pkwrt_pkg::REG_WINDOW_LEN:  prdata = {1'b0, win_q};
        default: prdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= pkwrt_pkg::MaxEntriesReset;
      win_q <= pkwrt_pkg::WindowLenReset;
    end else if (wr) begin
      if (paddr[3] == pkwrt_pkg::REG_MAX_ENTRIES) max_q <= pwdata[pkwrt_pkg::LimW-1:0];
      else win_q <= pwdata[pkwrt_pkg::TimeW-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/per_key_window_rate_tracker.sv =====
// per_key_window_rate_tracker: time from request accept to result is set by the linear key search,
// one table entry read per cycle from the table memory
// the back end takes a new request only after the last result is loaded; a clear skips the search
// a result that is not popped holds the back end in its output stage
// reset empties the table and the queues and loads register defaults
`default_nettype none
module per_key_window_rate_tracker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] key_id_i,
  input  logic [62:0] event_time_i,
  output logic        empty,
  input  logic        pop,
  output logic [30:0] peak_rate_o,
  output logic        key_present_o,
  output logic        dropped_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  pkwrt_pkg::req_t req_in, req_q;
  pkwrt_pkg::rsp_t rsp;
  logic req_v, req_take, busy;
  logic [pkwrt_pkg::LimW-1:0]  max_entries;
  logic [pkwrt_pkg::TimeW-1:0] window_len;

  assign req_in.cmd        = pkwrt_pkg::cmd_e'(cmd_i);
  assign req_in.key_id     = key_id_i;
  assign req_in.event_time = event_time_i;

  pkwrt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_i(req_in),
    .req_valid_o(req_v), .req_take_i(req_take), .req_o(req_q)
  );

  pkwrt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_v), .req_take_o(req_take), .req_i(req_q),
    .max_entries_i(max_entries), .window_len_i(window_len), .busy_o(busy),
    .empty_o(empty), .pop_i(pop), .rsp_o(rsp)
  );

  pkwrt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .max_entries_o(max_entries), .window_len_o(window_len)
  );

  assign peak_rate_o   = rsp.peak_rate;
  assign key_present_o = rsp.key_present;
  assign dropped_o     = rsp.dropped;

  a_drop_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && dropped_o |-> !key_present_o && peak_rate_o == '0) else $error("drop with key");
  a_present_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && key_present_o |-> peak_rate_o != '0) else $error("present with zero peak");
  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> busy) else $error("result without busy");
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking testbench for per_key_window_rate_tracker
// runs directed and random requests against an internal table predictor
// depends on pkwrt_pkg and the per_key_window_rate_tracker rtl
`default_nettype none
module tb;
  localparam int unsigned Depth = 64;
  localparam int unsigned SettleCycles = Depth + 16;
  localparam int unsigned StallLimit = 5000;
  localparam logic [3:0] AddrMaxEntries = 4'd0;
  localparam logic [3:0] AddrWindowLen = 4'd8;
  localparam int unsigned KeyW = pkwrt_pkg::KeyW;
  localparam int unsigned TimeW = pkwrt_pkg::TimeW;
  localparam int unsigned CountW = pkwrt_pkg::CountW;
  localparam int unsigned LimW = pkwrt_pkg::LimW;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam pkwrt_pkg::cmd_e CNote = pkwrt_pkg::CMD_NOTE;
  localparam pkwrt_pkg::cmd_e CQuery = pkwrt_pkg::CMD_QUERY;
  localparam pkwrt_pkg::cmd_e CClear = pkwrt_pkg::CMD_CLEAR;
  localparam pkwrt_pkg::cmd_e CNone = pkwrt_pkg::CMD_NONE;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] cmd_i = CQuery;
  logic [KeyW-1:0] key_id_i = '0;
  logic [TimeW-1:0] event_time_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CountW-1:0] peak_rate_o;
  logic key_present_o;
  logic dropped_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  per_key_window_rate_tracker #(.TABLE_DEPTH(Depth)) u_dut (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .key_id_i, .event_time_i,
    .empty, .pop, .peak_rate_o, .key_present_o, .dropped_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // predicted table contents
  logic [KeyW-1:0] tbl_key [Depth];
  logic [TimeW-1:0] tbl_start [Depth];
  logic [CountW-1:0] tbl_count [Depth];
  logic [CountW-1:0] tbl_peak [Depth];
  logic tbl_used [Depth];
  int unsigned tbl_fill;
  logic [LimW-1:0] cur_max_entries;
  logic [TimeW-1:0] cur_window_len;

  pkwrt_pkg::rsp_t expected_rsps[$];
  int unsigned err_count = 0;
  int unsigned reqs_sent = 0;
  int unsigned rsps_checked = 0;
  int unsigned drops_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles = 0;

  function automatic pkwrt_pkg::rsp_t track_request(pkwrt_pkg::cmd_e c, logic [KeyW-1:0] k,
                                                    logic [TimeW-1:0] t);
    pkwrt_pkg::rsp_t r;
    int slot;
    int unsigned limit;
    r = '0;
    slot = -1;
    limit = (cur_max_entries < Depth) ? cur_max_entries : Depth;
    if (c == CClear) begin
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      tbl_fill = 0;
      return r;
    end
    foreach (tbl_used[i]) if (slot < 0 && tbl_used[i] && tbl_key[i] == k) slot = i;
    if (c == CNote) begin
      if (slot >= 0) begin
        if (t >= tbl_start[slot] && t - tbl_start[slot] >= cur_window_len) begin
          tbl_start[slot] = t;
          tbl_count[slot] = 1;
        end else begin
          if (tbl_count[slot] != pkwrt_pkg::CountMax) tbl_count[slot]++;
          if (tbl_peak[slot] < tbl_count[slot]) tbl_peak[slot] = tbl_count[slot];
        end
      end else if (tbl_fill < limit) begin
        foreach (tbl_used[i]) if (slot < 0 && !tbl_used[i]) slot = i;
        tbl_used[slot] = 1'b1;
        tbl_key[slot] = k;
        tbl_start[slot] = t;
        tbl_count[slot] = 1;
        tbl_peak[slot] = 1;
        tbl_fill++;
      end else begin
        r.dropped = 1'b1;
      end
    end
    if (slot >= 0) begin
      r.peak_rate = tbl_peak[slot];
      r.key_present = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned exp);
    $display("mismatch on response %0d: %s got %0d expected %0d", rsps_checked, field, got, exp);
    err_count++;
  endtask

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    pkwrt_pkg::rsp_t e;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("outstanding requests", 0, 1);
        end else begin
          e = expected_rsps.pop_front();
          if (peak_rate_o !== e.peak_rate) report_mismatch("peak_rate", peak_rate_o, e.peak_rate);
          if (key_present_o !== e.key_present)
            report_mismatch("key_present", key_present_o, e.key_present);
          if (dropped_o !== e.dropped) report_mismatch("dropped", dropped_o, e.dropped);
          if (e.dropped) drops_seen++;
        end
        rsps_checked++;
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= StallLimit) begin
      $display("timeout: no progress for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(pkwrt_pkg::cmd_e c, logic [KeyW-1:0] k, logic [TimeW-1:0] t,
                              bit typed = 0, pkwrt_pkg::rsp_t typed_rsp = '0);
    pkwrt_pkg::rsp_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= c;
    key_id_i <= k;
    event_time_i <= t;
    do @(posedge clk_i); while (full);
    p = track_request(c, k, t);
    expected_rsps.push_back(typed ? typed_rsp : p);
    reqs_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [63:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrMaxEntries) cur_max_entries = data[LimW-1:0];
    else cur_window_len = data[TimeW-1:0];
  endtask

  task automatic configure(logic [LimW-1:0] max_e, logic [TimeW-1:0] wlen);
    drain_results();
    write_reg(AddrMaxEntries, 64'(max_e));
    write_reg(AddrWindowLen, 64'(wlen));
  endtask

  typedef struct {
    bit cfg;
    logic [LimW-1:0] max_e;
    logic [TimeW-1:0] wlen;
    pkwrt_pkg::cmd_e c;
    logic [KeyW-1:0] k;
    logic [TimeW-1:0] t;
    bit typed;
    pkwrt_pkg::rsp_t rsp;
  } step_t;

  // rsp fields: peak_rate, key_present, dropped
  step_t directed [21] = '{
    '{0, 0, 0, CQuery, 32'h0, 63'd0, 1, '{31'd0, 1'b0, 1'b0}},
    '{0, 0, 0, CNote, 32'h0, 63'd0, 1, '{31'd1, 1'b1, 1'b0}},
    '{0, 0, 0, CNote, 32'h0, 63'd5, 0, '0},
    '{0, 0, 0, CNote, 32'h0, 63'd1000000000, 0, '0},
    '{0, 0, 0, CNote, 32'hFFFFFFFF, TimeMax, 1, '{31'd1, 1'b1, 1'b0}},
    '{0, 0, 0, CNote, 32'hFFFFFFFF, 63'd0, 0, '0},
    '{0, 0, 0, CQuery, 32'hFFFFFFFF, 63'd0, 0, '0},
    '{0, 0, 0, CNone, 32'h0, TimeMax, 0, '0},
    '{0, 0, 0, CQuery, 32'h12345, 63'd0, 1, '{31'd0, 1'b0, 1'b0}},
    '{0, 0, 0, CClear, 32'hFFFFFFFF, TimeMax, 1, '{31'd0, 1'b0, 1'b0}},
    '{0, 0, 0, CQuery, 32'h0, 63'd0, 1, '{31'd0, 1'b0, 1'b0}},
    '{0, 0, 0, CNote, 32'hAAAAAAAA, {32'h55555555, 31'h55555555}, 1, '{31'd1, 1'b1, 1'b0}},
    '{0, 0, 0, CNote, 32'h55555555, {32'h2AAAAAAA, 31'h2AAAAAAA}, 1, '{31'd1, 1'b1, 1'b0}},
    '{1, 7'd0, 63'd0, CNote, 32'h7, 63'd10, 1, '{31'd0, 1'b0, 1'b1}},
    '{1, 7'd1, 63'd0, CClear, 32'h0, 63'd0, 1, '{31'd0, 1'b0, 1'b0}},
    '{0, 0, 0, CNote, 32'h1, 63'd100, 1, '{31'd1, 1'b1, 1'b0}},
    '{0, 0, 0, CNote, 32'h2, 63'd100, 1, '{31'd0, 1'b0, 1'b1}},
    '{0, 0, 0, CNote, 32'h1, 63'd100, 0, '0},
    '{0, 0, 0, CNote, 32'h1, 63'd50, 0, '0},
    '{0, 0, 0, CNote, 32'h1, 63'd40, 0, '0},
    '{0, 0, 0, CQuery, 32'h1, 63'd0, 0, '0}
  };

  logic [LimW-1:0] phase_max [6] = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd10, 7'd100};
  logic [TimeW-1:0] phase_wlen [6] = '{63'd1000000000, 63'd0, TimeMax, 63'd1, 63'd50, 63'd1000};
  int unsigned phase_pool [6] = '{8, 8, 96, 12, 16, 96};
  int unsigned send_pct [3] = '{36, 76, 0};
  int unsigned recv_pct [3] = '{76, 36, 0};

  initial begin
    logic [TimeW-1:0] now;
    logic [63:0] step;
    logic [KeyW-1:0] k;
    logic [TimeW-1:0] t;
    pkwrt_pkg::cmd_e c;
    int unsigned roll;
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    tbl_fill = 0;
    cur_max_entries = pkwrt_pkg::MaxEntriesReset;
    cur_window_len = pkwrt_pkg::WindowLenReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].cfg) configure(directed[i].max_e, directed[i].wlen);
      send_request(directed[i].c, directed[i].k, directed[i].t, directed[i].typed, directed[i].rsp);
    end

    for (int ph = 0; ph < 6; ph++) begin
      configure(phase_max[ph], phase_wlen[ph]);
      send_idle_pct = send_pct[ph / 2];
      recv_idle_pct = recv_pct[ph / 2];
      now = TimeW'({$urandom, $urandom});
      for (int n = 0; n < 125; n++) begin
        if (n == 60) begin
          push <= 1'b0;
          @(posedge clk_i);
          while (expected_rsps.size() != 0) @(posedge clk_i);
        end
        roll = $urandom_range(0, 99);
        if (roll < 72) c = CNote;
        else if (roll < 92) c = CQuery;
        else if (roll < 96) c = CNone;
        else c = CClear;
        if ($urandom_range(0, 19) == 0) k = $urandom;
        else k = 32'h1000 + $urandom_range(0, phase_pool[ph] - 1);
        step = {$urandom, $urandom} % (64'(phase_wlen[ph]) / 3 + 3);
        roll = $urandom_range(0, 19);
        if (roll == 0) now = TimeW'({$urandom, $urandom});
        else if (roll < 3) now = now - step[TimeW-1:0];
        else now = now + step[TimeW-1:0];
        t = ($urandom_range(0, 29) == 0) ? TimeW'({$urandom, $urandom}) : now;
        send_request(c, k, t);
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d requests over several limit and window settings, %0d responses checked",
             reqs_sent, rsps_checked);
    $display("saw %0d dropped notes", drops_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
